// File: sv/frsbp_pkg.sv
`timescale 1ns / 1ps

package frsbp_pkg;

  // Action codes carried by each input word.
  typedef enum logic [2:0] {
    ACT_TICK      = 3'd0,
    ACT_ARM       = 3'd1,
    ACT_START     = 3'd2,
    ACT_PAUSE     = 3'd3,
    ACT_RESUME    = 3'd4,
    ACT_STOP      = 3'd5,
    ACT_TAKE_TAIL = 3'd6
  } action_t;

  // Run status reported with every result word.
  typedef enum logic [2:0] {
    MODE_STOPPED = 3'd0,
    MODE_READY   = 3'd1,
    MODE_RUNNING = 3'd2,
    MODE_PAUSED  = 3'd3,
    MODE_OVERRUN = 3'd4
  } mode_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_BASE_PERIOD = 2'd0;
  localparam logic [1:0] REG_REMAINDER   = 2'd1;
  localparam logic [1:0] REG_DIVISOR     = 2'd2;

  // Configuration reset values.
  localparam logic [15:0] BASE_PERIOD_RESET = 16'd362;
  localparam logic [15:0] REMAINDER_RESET   = 16'd35800;
  localparam logic [15:0] DIVISOR_RESET     = 16'd44100;

  // Bits in one packed byte.
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  // Timing configuration seen by the sampling engine.
  typedef struct packed {
    logic [15:0] base_period_ticks;
    logic [15:0] period_remainder;
    logic [15:0] rate_divisor;
  } cfg_t;

  // One result word.
  typedef struct packed {
    logic       accepted;
    logic       byte_valid;
    logic [7:0] data_byte;
    logic [3:0] bit_count;
    logic       is_tail;
    mode_t      run_status;
    logic [3:0] pending_count;
  } result_t;

endpackage

// File: sv/frsbp_cfg.sv
`timescale 1ns / 1ps

module frsbp_cfg (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output frsbp_pkg::cfg_t    cfg
);

  // Timing registers; an index past the last register is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_period_ticks <= frsbp_pkg::BASE_PERIOD_RESET;
      cfg.period_remainder  <= frsbp_pkg::REMAINDER_RESET;
      cfg.rate_divisor      <= frsbp_pkg::DIVISOR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        frsbp_pkg::REG_BASE_PERIOD: cfg.base_period_ticks <= cfg_data;
        frsbp_pkg::REG_REMAINDER:   cfg.period_remainder  <= cfg_data;
        frsbp_pkg::REG_DIVISOR:     cfg.rate_divisor      <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: sv/frsbp_core.sv
`timescale 1ns / 1ps

module frsbp_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  logic [2:0]           action,
  input  logic                 line_level,
  input  logic                 sink_ready,
  input  frsbp_pkg::cfg_t      cfg,
  output frsbp_pkg::result_t   result
);

  frsbp_pkg::mode_t mode, mode_next;
  logic [15:0] tick_count, tick_count_next;
  logic [15:0] current_period, current_period_next;
  logic [15:0] phase_accum, phase_accum_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [3:0]  shift_count, shift_count_next;
  logic [7:0]  held_tail_byte, held_tail_byte_next;
  logic [3:0]  held_tail_count, held_tail_count_next;
  logic        tail_present, tail_present_next;

  logic [16:0] phase_sum;
  logic        phase_wrap;
  logic [15:0] phase_after;
  logic [15:0] period_after;
  logic [7:0]  merged_byte;
  logic [3:0]  packed_count;

  // Fractional step: one extra tick when the phase reaches the divisor.
  always_comb begin
    phase_sum    = {1'b0, phase_accum} + {1'b0, cfg.period_remainder};
    phase_wrap   = (phase_sum >= {1'b0, cfg.rate_divisor});
    phase_after  = phase_wrap ? 16'(phase_sum - {1'b0, cfg.rate_divisor}) : phase_sum[15:0];
    period_after = phase_wrap ? cfg.base_period_ticks : cfg.base_period_ticks - 16'd1;
  end

  // The packer with the current sample added at the next free bit.
  always_comb begin
    merged_byte  = shift_byte | ({7'd0, line_level} << shift_count[2:0]);
    packed_count = shift_count + 4'd1;
  end

  // Next state and result word for one input word.
  always_comb begin
    mode_next            = mode;
    tick_count_next      = tick_count;
    current_period_next  = current_period;
    phase_accum_next     = phase_accum;
    shift_byte_next      = shift_byte;
    shift_count_next     = shift_count;
    held_tail_byte_next  = held_tail_byte;
    held_tail_count_next = held_tail_count;
    tail_present_next    = tail_present;
    result.accepted      = 1'b0;
    result.byte_valid    = 1'b0;
    result.data_byte     = 8'd0;
    result.bit_count     = 4'd0;
    result.is_tail       = 1'b0;

    unique case (action)
      frsbp_pkg::ACT_TICK: begin
        if (mode == frsbp_pkg::MODE_RUNNING) begin
          result.accepted = 1'b1;
          if (tick_count != current_period) begin
            tick_count_next = tick_count + 16'd1;
          end else begin
            tick_count_next  = 16'd0;
            shift_byte_next  = merged_byte;
            shift_count_next = packed_count;
            if (packed_count >= frsbp_pkg::BITS_PER_BYTE && !sink_ready) begin
              // Keep the full byte and freeze the period.
              mode_next = frsbp_pkg::MODE_OVERRUN;
            end else begin
              if (packed_count >= frsbp_pkg::BITS_PER_BYTE) begin
                result.byte_valid = 1'b1;
                result.data_byte  = merged_byte;
                result.bit_count  = frsbp_pkg::BITS_PER_BYTE;
                shift_byte_next   = 8'd0;
                shift_count_next  = 4'd0;
              end
              phase_accum_next    = phase_after;
              current_period_next = period_after;
            end
          end
        end
      end
      frsbp_pkg::ACT_ARM: begin
        result.accepted      = 1'b1;
        tick_count_next      = 16'd0;
        phase_accum_next     = 16'd0;
        shift_byte_next      = 8'd0;
        shift_count_next     = 4'd0;
        held_tail_byte_next  = 8'd0;
        held_tail_count_next = 4'd0;
        tail_present_next    = 1'b0;
        mode_next            = frsbp_pkg::MODE_READY;
      end
      frsbp_pkg::ACT_START: begin
        if (mode == frsbp_pkg::MODE_READY) begin
          result.accepted     = 1'b1;
          tick_count_next     = 16'd0;
          current_period_next = cfg.base_period_ticks - 16'd1;
          mode_next           = frsbp_pkg::MODE_RUNNING;
        end
      end
      frsbp_pkg::ACT_PAUSE: begin
        if (mode == frsbp_pkg::MODE_RUNNING) begin
          result.accepted = 1'b1;
          mode_next       = frsbp_pkg::MODE_PAUSED;
        end
      end
      frsbp_pkg::ACT_RESUME: begin
        if (mode == frsbp_pkg::MODE_PAUSED) begin
          result.accepted     = 1'b1;
          tick_count_next     = 16'd0;
          current_period_next = cfg.base_period_ticks - 16'd1;
          mode_next           = frsbp_pkg::MODE_RUNNING;
        end
      end
      frsbp_pkg::ACT_STOP: begin
        result.accepted = 1'b1;
        // A non-empty packer replaces any held tail.
        if (shift_count != 4'd0) begin
          held_tail_byte_next  = shift_byte;
          held_tail_count_next = shift_count;
          tail_present_next    = 1'b1;
        end
        shift_byte_next  = 8'd0;
        shift_count_next = 4'd0;
        if (mode != frsbp_pkg::MODE_OVERRUN) begin
          mode_next = frsbp_pkg::MODE_STOPPED;
        end
      end
      frsbp_pkg::ACT_TAKE_TAIL: begin
        if (tail_present) begin
          result.accepted      = 1'b1;
          result.byte_valid    = 1'b1;
          result.data_byte     = held_tail_byte;
          result.bit_count     = held_tail_count;
          result.is_tail       = 1'b1;
          held_tail_byte_next  = 8'd0;
          held_tail_count_next = 4'd0;
          tail_present_next    = 1'b0;
        end
      end
      default: ;
    endcase

    result.run_status    = mode_next;
    result.pending_count = tail_present_next ? held_tail_count_next : shift_count_next;
  end

  // State registers advance only when a word is processed.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= frsbp_pkg::MODE_STOPPED;
      tick_count      <= 16'd0;
      current_period  <= 16'd0;
      phase_accum     <= 16'd0;
      shift_byte      <= 8'd0;
      shift_count     <= 4'd0;
      held_tail_byte  <= 8'd0;
      held_tail_count <= 4'd0;
      tail_present    <= 1'b0;
    end else if (fire) begin
      mode            <= mode_next;
      tick_count      <= tick_count_next;
      current_period  <= current_period_next;
      phase_accum     <= phase_accum_next;
      shift_byte      <= shift_byte_next;
      shift_count     <= shift_count_next;
      held_tail_byte  <= held_tail_byte_next;
      held_tail_count <= held_tail_count_next;
      tail_present    <= tail_present_next;
    end
  end

endmodule

// File: sv/fractional_rate_bit_sampler_packer.sv
`timescale 1ns / 1ps

// Fractional-rate one-bit sampler and LSB-first byte packer.
// Input channel (in_valid / in_stall) carries one word per timer tick or
// command: action, line_level and sink_ready. Output channel (out_valid /
// out_stall) returns exactly one result word per input word, in order.
// Timing registers are written through cfg_we / cfg_index / cfg_data; the
// user must do so only while the block is idle, which it does not enforce.
// They take effect for the next word. Throughput: one word per cycle unless
// out_stall holds the output register. An accepted word is registered in the
// input register, processed by the engine once the output register is free
// or draining, and held in the output register. The state update is a single
// pass of a 17-bit phase add and compare, which sets the cycle.
// When out_stall holds a full output register, the processed word waits
// there, one more word is held in the input register and in_stall rises
// until the output is taken. Reset clears both registers, returns the timing
// registers to their defaults and puts the engine in the stopped state.
module fractional_rate_bit_sampler_packer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  action,
  input  logic        line_level,
  input  logic        sink_ready,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        accepted,
  output logic        byte_valid,
  output logic [7:0]  data_byte,
  output logic [3:0]  bit_count,
  output logic        is_tail,
  output logic [2:0]  run_status,
  output logic [3:0]  pending_count,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  frsbp_pkg::cfg_t    cfg;
  frsbp_pkg::result_t result;
  frsbp_pkg::result_t out_word;

  logic       hold_valid;
  logic [2:0] hold_action;
  logic       hold_level;
  logic       hold_ready;
  logic       advance;

  frsbp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The held word is processed when the output register is free or draining.
  assign advance  = hold_valid && (!out_valid || !out_stall);
  assign in_stall = hold_valid && !advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      hold_action <= action;
      hold_level  <= line_level;
      hold_ready  <= sink_ready;
    end
  end

  frsbp_core u_core (
    .clk        (clk),
    .rst        (rst),
    .fire       (advance),
    .action     (hold_action),
    .line_level (hold_level),
    .sink_ready (hold_ready),
    .cfg        (cfg),
    .result     (result)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= result;
    end
  end

  assign accepted      = out_word.accepted;
  assign byte_valid    = out_word.byte_valid;
  assign data_byte     = out_word.data_byte;
  assign bit_count     = out_word.bit_count;
  assign is_tail       = out_word.is_tail;
  assign run_status    = out_word.run_status;
  assign pending_count = out_word.pending_count;

endmodule

// File: sv/frsbp_checker.sv
`timescale 1ns / 1ps

module frsbp_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic       accepted,
  input logic       byte_valid,
  input logic [7:0] data_byte,
  input logic [3:0] bit_count,
  input logic       is_tail
);

  // A stalled result word stays valid with its byte and bit count unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(data_byte) && $stable(bit_count))
    else $error("stalled result word changed");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word present after reset");

  // No byte without a byte: the byte fields read zero.
  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> data_byte == 8'd0 && bit_count == 4'd0 && !is_tail)
    else $error("byte fields set without a byte");

  // A byte only comes from an accepted word; a full byte has eight bits.
  a_byte_source: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_valid |-> accepted && (is_tail || bit_count == 4'd8))
    else $error("byte emitted with inconsistent fields");

  // A tail byte carries at least one bit.
  a_tail_bits: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_tail |-> byte_valid && bit_count != 4'd0)
    else $error("empty tail byte emitted");

endmodule

bind fractional_rate_bit_sampler_packer frsbp_checker u_frsbp_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .accepted   (accepted),
  .byte_valid (byte_valid),
  .data_byte  (data_byte),
  .bit_count  (bit_count),
  .is_tail    (is_tail)
);

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  // The one action code that the block must ignore, and the unused register index.
  localparam logic [2:0] ACT_UNUSED = 3'd7;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  localparam int DRAIN_CYCLES = 4;
  localparam int HOLDOFF_CYCLES = 60;
  localparam int WATCHDOG_LIMIT = 5000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  action = frsbp_pkg::ACT_TICK;
  logic        line_level = 1'b0;
  logic        sink_ready = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        accepted;
  logic        byte_valid;
  logic [7:0]  data_byte;
  logic [3:0]  bit_count;
  logic        is_tail;
  logic [2:0]  run_status;
  logic [3:0]  pending_count;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = frsbp_pkg::REG_BASE_PERIOD;
  logic [15:0] cfg_data = 16'd0;

  fractional_rate_bit_sampler_packer dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .action        (action),
    .line_level    (line_level),
    .sink_ready    (sink_ready),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .accepted      (accepted),
    .byte_valid    (byte_valid),
    .data_byte     (data_byte),
    .bit_count     (bit_count),
    .is_tail       (is_tail),
    .run_status    (run_status),
    .pending_count (pending_count),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Timing registers and sampler state as the block should hold them.
  logic [15:0]      cfg_base = frsbp_pkg::BASE_PERIOD_RESET;
  logic [15:0]      cfg_rem = frsbp_pkg::REMAINDER_RESET;
  logic [15:0]      cfg_div = frsbp_pkg::DIVISOR_RESET;
  frsbp_pkg::mode_t st_mode = frsbp_pkg::MODE_STOPPED;
  logic [15:0]      st_ticks = '0;
  logic [15:0]      st_period = '0;
  logic [15:0]      st_phase = '0;
  logic [7:0]       st_shift = '0;
  logic [3:0]       st_nbits = '0;
  logic [7:0]       st_tail = '0;
  logic [3:0]       st_tail_bits = '0;
  logic             st_tail_held = 1'b0;

  // Result words still owed by the block, oldest first.
  frsbp_pkg::result_t results_due[$];

  int failures = 0;
  int useful_words = 0;
  int bytes_out = 0;
  int tails_out = 0;
  int overruns_seen = 0;
  int settings_used = 0;
  int sender_idle_pct = 0;
  int stall_pct = 0;
  int holdoff_left = 0;
  int holdoff_asks = 0;
  int holdoff_served = 0;
  int quiet_cycles = 0;

  // Next sample period: base ticks plus one when the 17-bit phase sum reaches the divisor.
  function automatic void advance_sample_period();
    logic [16:0] sum;
    logic [15:0] ticks;
    ticks = cfg_base;
    sum = {1'b0, st_phase} + {1'b0, cfg_rem};
    if (sum >= {1'b0, cfg_div}) begin
      sum = sum - {1'b0, cfg_div};
      ticks = ticks + 16'd1;
    end
    st_phase = sum[15:0];
    st_period = ticks - 16'd1;
  endfunction

  // Apply one word to the predicted state and return the result word it should give.
  function automatic frsbp_pkg::result_t sample_and_pack(input logic [2:0] act,
                                                         input logic lvl, input logic rdy);
    frsbp_pkg::result_t r;
    r = '0;
    case (act)
      frsbp_pkg::ACT_TICK: if (st_mode == frsbp_pkg::MODE_RUNNING) begin
        r.accepted = 1'b1;
        if (st_ticks != st_period) begin
          st_ticks = st_ticks + 16'd1;
        end else begin
          st_ticks = '0;
          if (lvl) st_shift[st_nbits[2:0]] = 1'b1;
          st_nbits = st_nbits + 4'd1;
          if (st_nbits >= frsbp_pkg::BITS_PER_BYTE && !rdy) begin
            // Sink not ready: the full byte stays in the packer.
            st_mode = frsbp_pkg::MODE_OVERRUN;
            overruns_seen++;
          end else begin
            if (st_nbits >= frsbp_pkg::BITS_PER_BYTE) begin
              r.byte_valid = 1'b1;
              r.data_byte = st_shift;
              r.bit_count = frsbp_pkg::BITS_PER_BYTE;
              st_shift = '0;
              st_nbits = '0;
              bytes_out++;
            end
            advance_sample_period();
          end
        end
      end
      frsbp_pkg::ACT_ARM: begin
        r.accepted = 1'b1;
        st_ticks = '0;
        st_phase = '0;
        st_shift = '0;
        st_nbits = '0;
        st_tail = '0;
        st_tail_bits = '0;
        st_tail_held = 1'b0;
        st_mode = frsbp_pkg::MODE_READY;
      end
      frsbp_pkg::ACT_START, frsbp_pkg::ACT_RESUME: begin
        if ((act == frsbp_pkg::ACT_START && st_mode == frsbp_pkg::MODE_READY) ||
            (act == frsbp_pkg::ACT_RESUME && st_mode == frsbp_pkg::MODE_PAUSED)) begin
          r.accepted = 1'b1;
          st_ticks = '0;
          st_period = cfg_base - 16'd1;
          st_mode = frsbp_pkg::MODE_RUNNING;
        end
      end
      frsbp_pkg::ACT_PAUSE: if (st_mode == frsbp_pkg::MODE_RUNNING) begin
        r.accepted = 1'b1;
        st_mode = frsbp_pkg::MODE_PAUSED;
      end
      frsbp_pkg::ACT_STOP: begin
        r.accepted = 1'b1;
        // A partial byte moves to the tail; an empty packer leaves the tail alone.
        if (st_nbits != 0) begin
          st_tail = st_shift;
          st_tail_bits = st_nbits;
          st_tail_held = 1'b1;
        end
        st_shift = '0;
        st_nbits = '0;
        if (st_mode != frsbp_pkg::MODE_OVERRUN) st_mode = frsbp_pkg::MODE_STOPPED;
      end
      frsbp_pkg::ACT_TAKE_TAIL: if (st_tail_held) begin
        r.accepted = 1'b1;
        r.byte_valid = 1'b1;
        r.data_byte = st_tail;
        r.bit_count = st_tail_bits;
        r.is_tail = 1'b1;
        st_tail = '0;
        st_tail_bits = '0;
        st_tail_held = 1'b0;
        tails_out++;
      end
      default: ;
    endcase
    r.run_status = st_mode;
    r.pending_count = st_tail_held ? st_tail_bits : st_nbits;
    return r;
  endfunction

  // Offer one word, hold it until accepted, then record the result it should give.
  // Called and returning at a falling edge; valid stays high for a following word.
  task automatic send_word(input logic [2:0] act, input logic lvl, input logic rdy);
    frsbp_pkg::result_t r;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    line_level <= lvl;
    sink_ready <= rdy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = sample_and_pack(act, lvl, rdy);
    results_due.push_back(r);
    if (r.accepted) useful_words++;
    @(negedge clk);
  endtask

  task automatic send_cmd(input logic [2:0] act);
    send_word(act, 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  task automatic run_ticks(input int n, input int level_pct, input int ready_pct);
    repeat (n) begin
      send_word(frsbp_pkg::ACT_TICK, $urandom_range(99) < level_pct,
                $urandom_range(99) < ready_pct);
    end
  endtask

  // Stop offering words and wait until every owed result word has come back.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Write all timing registers while the block is idle, plus a write to the unused index.
  task automatic configure_timing(input logic [15:0] base, input logic [15:0] rem,
                                  input logic [15:0] div);
    wait_results_drained();
    cfg_we <= 1'b1;
    cfg_index <= frsbp_pkg::REG_BASE_PERIOD;
    cfg_data <= base;
    @(negedge clk);
    cfg_index <= frsbp_pkg::REG_REMAINDER;
    cfg_data <= rem;
    @(negedge clk);
    cfg_index <= frsbp_pkg::REG_DIVISOR;
    cfg_data <= div;
    @(negedge clk);
    cfg_index <= REG_UNUSED;
    cfg_data <= 16'($urandom);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    cfg_base = base;
    cfg_rem = rem;
    cfg_div = div;
    settings_used++;
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  // Compare each result word taken from the block with the oldest owed one.
  always @(posedge clk) begin
    frsbp_pkg::result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        $error("result word with none owed");
        failures++;
      end else begin
        want = results_due.pop_front();
        check_field("accepted", want.accepted, accepted);
        check_field("byte_valid", want.byte_valid, byte_valid);
        check_field("data_byte", want.data_byte, data_byte);
        check_field("bit_count", want.bit_count, bit_count);
        check_field("is_tail", want.is_tail, is_tail);
        check_field("run_status", want.run_status, run_status);
        check_field("pending_count", want.pending_count, pending_count);
      end
    end
  end

  // Receiver: random stalls, or a long counted hold-off when one is asked for.
  always @(negedge clk) begin
    if (holdoff_asks != holdoff_served) begin
      holdoff_left = HOLDOFF_CYCLES;
      holdoff_served = holdoff_asks;
    end
    if (holdoff_left != 0) begin
      out_stall <= 1'b1;
      holdoff_left = holdoff_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: end the run if no word moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Commands in all modes but overrun at reset timing; stopped ticks and code 7 are ignored.
  task automatic test_commands_from_reset();
    send_word(frsbp_pkg::ACT_TICK, 1'b1, 1'b1);
    send_cmd(frsbp_pkg::ACT_TAKE_TAIL);
    send_cmd(frsbp_pkg::ACT_PAUSE);
    send_cmd(frsbp_pkg::ACT_RESUME);
    send_cmd(frsbp_pkg::ACT_START);
    send_cmd(frsbp_pkg::ACT_STOP);
    send_cmd(ACT_UNUSED);
    send_cmd(frsbp_pkg::ACT_ARM);
    send_cmd(frsbp_pkg::ACT_ARM);
    send_cmd(frsbp_pkg::ACT_PAUSE);
    send_cmd(frsbp_pkg::ACT_RESUME);
    send_cmd(frsbp_pkg::ACT_START);
    send_cmd(frsbp_pkg::ACT_START);
    send_cmd(frsbp_pkg::ACT_PAUSE);
    send_cmd(frsbp_pkg::ACT_PAUSE);
    send_word(frsbp_pkg::ACT_TICK, 1'b0, 1'b0);
    send_cmd(frsbp_pkg::ACT_START);
    send_cmd(frsbp_pkg::ACT_RESUME);
    send_cmd(ACT_UNUSED);
    send_cmd(frsbp_pkg::ACT_STOP);
    send_cmd(frsbp_pkg::ACT_RESUME);
  endtask

  // Partial bytes go to the tail on stop; an empty stop keeps it, arm clears it.
  task automatic test_tail_handoff();
    configure_timing(16'd4, 16'd0, 16'd1);
    send_cmd(frsbp_pkg::ACT_ARM);
    send_cmd(frsbp_pkg::ACT_START);
    run_ticks(14, 50, 100);
    send_cmd(frsbp_pkg::ACT_STOP);
    send_cmd(frsbp_pkg::ACT_TAKE_TAIL);
    send_cmd(frsbp_pkg::ACT_TAKE_TAIL);
    send_cmd(frsbp_pkg::ACT_ARM);
    send_cmd(frsbp_pkg::ACT_START);
    run_ticks(22, 50, 100);
    send_cmd(frsbp_pkg::ACT_STOP);
    send_cmd(frsbp_pkg::ACT_STOP);
    send_cmd(frsbp_pkg::ACT_ARM);
    send_cmd(frsbp_pkg::ACT_TAKE_TAIL);
  endtask

  // An all-ones byte goes out, then an all-zeros byte meets a busy sink and overruns.
  task automatic test_overrun();
    send_cmd(frsbp_pkg::ACT_START);
    run_ticks(34, 100, 100);
    run_ticks(40, 0, 0);
    send_cmd(frsbp_pkg::ACT_START);
    send_cmd(frsbp_pkg::ACT_PAUSE);
    send_cmd(frsbp_pkg::ACT_RESUME);
    send_cmd(frsbp_pkg::ACT_STOP);
    send_cmd(frsbp_pkg::ACT_TAKE_TAIL);
    send_cmd(frsbp_pkg::ACT_STOP);
    send_cmd(frsbp_pkg::ACT_ARM);
  endtask

  // Phase sums past 16 bits, a remainder above the divisor, a zero divisor and the
  // longest base period.
  task automatic test_phase_extremes();
    configure_timing(16'd2, 16'd65534, 16'd65535);
    send_cmd(frsbp_pkg::ACT_ARM);
    send_cmd(frsbp_pkg::ACT_START);
    run_ticks(60, 50, 100);
    send_cmd(frsbp_pkg::ACT_STOP);
    send_cmd(frsbp_pkg::ACT_TAKE_TAIL);
    configure_timing(16'd3, 16'd50000, 16'd40000);
    send_cmd(frsbp_pkg::ACT_ARM);
    send_cmd(frsbp_pkg::ACT_START);
    run_ticks(60, 50, 100);
    send_cmd(frsbp_pkg::ACT_STOP);
    send_cmd(frsbp_pkg::ACT_TAKE_TAIL);
    configure_timing(16'd2, 16'd7, 16'd0);
    send_cmd(frsbp_pkg::ACT_ARM);
    send_cmd(frsbp_pkg::ACT_START);
    run_ticks(40, 50, 100);
    send_cmd(frsbp_pkg::ACT_STOP);
    send_cmd(frsbp_pkg::ACT_TAKE_TAIL);
    configure_timing(16'd65535, 16'd0, 16'd1);
    send_cmd(frsbp_pkg::ACT_ARM);
    send_cmd(frsbp_pkg::ACT_START);
    run_ticks(20, 50, 100);
    send_cmd(frsbp_pkg::ACT_PAUSE);
    send_cmd(frsbp_pkg::ACT_RESUME);
    run_ticks(10, 50, 100);
    send_cmd(frsbp_pkg::ACT_STOP);
  endtask

  // The receiver holds off long enough to back up the input; then the sender pauses to drain.
  task automatic test_backpressure();
    configure_timing(16'd2, 16'd1, 16'd3);
    sender_idle_pct = 0;
    stall_pct = 0;
    send_cmd(frsbp_pkg::ACT_ARM);
    send_cmd(frsbp_pkg::ACT_START);
    holdoff_asks++;
    run_ticks(100, 50, 100);
    wait_results_drained();
    run_ticks(60, 50, 100);
    send_cmd(frsbp_pkg::ACT_STOP);
    send_cmd(frsbp_pkg::ACT_TAKE_TAIL);
  endtask

  // One well-formed run with random content, pauses and some stray words mixed in.
  task automatic random_session();
    int pick;
    if ($urandom_range(9) != 0) send_cmd(frsbp_pkg::ACT_ARM);
    send_cmd(frsbp_pkg::ACT_START);
    repeat ($urandom_range(2, 6)) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        run_ticks($urandom_range(5, 20), 50, 92);
      end else if (pick < 80) begin
        send_cmd(frsbp_pkg::ACT_PAUSE);
        run_ticks($urandom_range(1, 6), 50, 50);
        send_cmd(frsbp_pkg::ACT_RESUME);
      end else if (pick < 92) begin
        send_cmd(3'($urandom_range(7)));
      end else begin
        send_cmd(frsbp_pkg::ACT_TAKE_TAIL);
      end
    end
    send_cmd(frsbp_pkg::ACT_STOP);
    if ($urandom_range(3) != 0) send_cmd(frsbp_pkg::ACT_TAKE_TAIL);
  endtask

  // Random sessions under each idling pattern, two random timing settings per pattern.
  task automatic test_random_sessions();
    int idle_set[4] = '{0, 77, 0, 36};
    int stall_set[4] = '{0, 0, 77, 36};
    for (int p = 0; p < 4; p++) begin
      for (int k = 0; k < 2; k++) begin
        configure_timing(16'($urandom_range(1, 5)), 16'($urandom_range(0, 65534)),
                         16'($urandom_range(1, 65535)));
        sender_idle_pct = idle_set[p];
        stall_pct = stall_set[p];
        repeat (2) random_session();
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_commands_from_reset();
    test_tail_handoff();
    test_overrun();
    test_phase_extremes();
    test_backpressure();
    test_random_sessions();
    sender_idle_pct = 0;
    stall_pct = 0;
    wait_results_drained();
    $display("Covered %0d counted words over %0d timing settings and four idling patterns.",
             useful_words, settings_used);
    $display("Saw %0d packed bytes, %0d tails and %0d overruns.",
             bytes_out, tails_out, overruns_seen);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
